@@ hdl/b64e_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg: shared types and helpers for the base64 stream encoder
// Item structs, the group phase encoding and the sextet-to-ASCII lookup.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int GrpChars = 4;
  localparam logic [6:0] PAD_CHAR = 7'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } out_item_t;

  // One accepted byte, already turned into the characters it produces.
  typedef struct packed {
    logic [2:0]                   cnt;
    logic [GrpChars-1:0][6:0]     chars;
    logic                         last;
  } grp_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_ONE   = 2'd1,
    PH_TWO   = 2'd2
  } phase_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] c;
    c = 7'h41;
    case (v) inside
      [6'd0:6'd25]:  c = 7'h41 + {1'b0, v};
      [6'd26:6'd51]: c = 7'h61 + {1'b0, v} - 7'd26;
      [6'd52:6'd61]: c = 7'h30 + {1'b0, v} - 7'd52;
      6'd62:         c = 7'h2B;
      default:       c = 7'h2F;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/b64e_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front: byte intake and group tracking
// Tracks the position in the three-byte group and the leftover bits, and
// turns each accepted byte into one queue entry of one to four characters.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  b64e_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push,
  output b64e_pkg::grp_t    push_grp
);

  b64e_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       carry_r, carry_nxt;

  logic [7:0] b;
  logic       fin;

  assign b        = in_data.data_byte;
  assign fin      = in_data.final_byte;
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= b64e_pkg::PH_START;
      carry_r <= 4'd0;
    end else if (push) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

  always_comb begin
    phase_nxt        = b64e_pkg::PH_START;
    carry_nxt        = 4'd0;
    push_grp.cnt     = 3'd1;
    push_grp.chars   = '0;
    push_grp.last    = fin;
    case (phase_r)
      b64e_pkg::PH_ONE: begin
        push_grp.chars[0] = b64e_pkg::sextet_char({carry_r[1:0], b[7:4]});
        carry_nxt         = b[3:0];
        phase_nxt         = b64e_pkg::PH_TWO;
        if (fin) begin
          push_grp.chars[1] = b64e_pkg::sextet_char({b[3:0], 2'b00});
          push_grp.chars[2] = b64e_pkg::PAD_CHAR;
          push_grp.cnt      = 3'd3;
        end
      end
      b64e_pkg::PH_TWO: begin
        push_grp.chars[0] = b64e_pkg::sextet_char({carry_r[3:0], b[7:6]});
        push_grp.chars[1] = b64e_pkg::sextet_char(b[5:0]);
        push_grp.cnt      = 3'd2;
      end
      default: begin
        push_grp.chars[0] = b64e_pkg::sextet_char(b[7:2]);
        carry_nxt         = {2'b00, b[1:0]};
        phase_nxt         = b64e_pkg::PH_ONE;
        if (fin) begin
          push_grp.chars[1] = b64e_pkg::sextet_char({b[1:0], 4'b0000});
          push_grp.chars[2] = b64e_pkg::PAD_CHAR;
          push_grp.chars[3] = b64e_pkg::PAD_CHAR;
          push_grp.cnt      = 3'd4;
        end
      end
    endcase
    // drop back to group start after the final byte
    if (fin) begin
      phase_nxt = b64e_pkg::PH_START;
      carry_nxt = 4'd0;
    end
  end

endmodule

@@ hdl/b64e_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue: two-entry group queue
// Decouples byte intake from character output.
// ----------------------------------------------------------------------------
module b64e_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64e_pkg::grp_t push_grp,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output b64e_pkg::grp_t head_grp
);

  b64e_pkg::grp_t mem_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_grp   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ hdl/b64e_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back: character serializer
// Walks queue entries into the output register one char per unstalled cycle.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  b64e_pkg::grp_t      head_grp,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output b64e_pkg::out_item_t out_data
);

  logic [1:0]          idx_q_r;
  logic                out_valid_r;
  b64e_pkg::out_item_t out_data_r;
  logic                load;
  logic                at_end;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign load   = head_valid && (!out_valid_r || !out_stall);
  assign at_end = ({1'b0, idx_q_r} == (head_grp.cnt - 3'd1));
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_q_r     <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_q_r     <= at_end ? 2'd0 : idx_q_r + 2'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: hold while stalled, advance on load
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.out_char  <= head_grp.chars[idx_q_r];
      out_data_r.last_char <= head_grp.last && at_end;
    end
  end

endmodule

@@ hdl/base64_stream_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder: streaming RFC 4648 base64 encoder
// Byte in, ASCII characters out, with flush and '=' padding on the last byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions carry one message byte and a final_byte flag; output
//   transactions carry one ASCII character, last_char set on the final
//   character of a message. Both channels complete on valid high, stall low.
//   Each byte yields one to four characters; the byte with final_byte set
//   flushes the partial group and appends the '=' pads.
//   An accepted byte is written into the queue entry and then loaded into
//   the output register. The output side moves one character per cycle
//   while out_stall is low; a byte yields 1.33 characters on average, up
//   to four at flush.
//   A two-entry queue between intake and output lets the input take one byte
//   per cycle until it fills; in_stall is high only while the queue is full.
//   Reset clears the group position, empties the queue and clears out_valid.
//   When the receiver stalls, the current character holds and the queue
//   fills, after which in_stall rises.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  b64e_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output b64e_pkg::out_item_t out_data
);

  logic           q_full;
  logic           push;
  logic           pop;
  logic           head_valid;
  b64e_pkg::grp_t push_grp;
  b64e_pkg::grp_t head_grp;

  b64e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_grp (push_grp)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_grp   (push_grp),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_grp   (head_grp)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_grp   (head_grp),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
